### rtl/iis_pkg.sv
// ----------------------------------------------------------------------------
// Integral image stream package
// Field types, register indexes and reset values shared by the interfaces,
// the core and the checker.
// ----------------------------------------------------------------------------
`default_nettype none

package iis_pkg;

  // Field widths
  localparam int PIXEL_W     = 8;
  localparam int SUM_W       = 28;
  localparam int SQ_W        = 36;
  localparam int SQ_STORE_W  = 37;
  localparam int CFG_W       = 11;
  localparam int CFG_IDX_W   = 2;

  typedef logic [PIXEL_W-1:0]    pixel_t;
  typedef logic [SUM_W-1:0]      sum_t;
  typedef logic [SQ_W-1:0]       sq_t;
  typedef logic [SQ_STORE_W-1:0] sq_store_t;
  typedef logic [CFG_W-1:0]      cfg_data_t;
  typedef logic [CFG_IDX_W-1:0]  cfg_idx_t;

  // Register indexes
  localparam cfg_idx_t REG_IMAGE_WIDTH  = 2'd0;
  localparam cfg_idx_t REG_IMAGE_HEIGHT = 2'd1;

  // Register reset values
  localparam cfg_data_t IMAGE_WIDTH_RST  = 11'd1024;
  localparam cfg_data_t IMAGE_HEIGHT_RST = 11'd1024;

endpackage

`default_nettype wire

### rtl/iis_if.sv
// ----------------------------------------------------------------------------
// Integral image stream channels
// Valid/ready channels for input pixels and for integral image results.
// ----------------------------------------------------------------------------
`default_nettype none

interface iis_pixel_if;
  import iis_pkg::*;

  logic   valid;
  logic   ready;
  pixel_t pixel;

  modport source (output valid, output pixel, input ready);
  modport sink   (input valid, input pixel, output ready);
endinterface

interface iis_result_if;
  import iis_pkg::*;

  logic valid;
  logic ready;
  sum_t area_sum;
  sq_t  area_square_sum;
  logic row_end;
  logic frame_end;

  modport source (output valid, output area_sum, output area_square_sum,
                  output row_end, output frame_end, input ready);
  modport sink   (input valid, input area_sum, input area_square_sum,
                  input row_end, input frame_end, output ready);
endinterface

`default_nettype wire

### rtl/integral_image_stream_core.sv
// ----------------------------------------------------------------------------
// Integral image stream core
// Summed-area table and squared summed-area table over 8-bit raster pixels,
// with one line store per sum holding the previous row's results.
// ----------------------------------------------------------------------------
// Pipeline: stage one registers a transferred pixel with its line store read;
//   stage two adds the previous row and registers the result when it frees up.
// Throughput: one pixel per cycle while the result side is ready; the line
//   store is read and written once a cycle, bypassing a same-column read.
// Reset: counters and row sums clear, both sizes return to 1024 and the
//   pipeline empties; the line stores are not cleared (row zero ignores them).
`default_nettype none

module integral_image_stream_core #(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 1024
) (
  input  wire                 clk,
  input  wire                 rst_n,
  iis_pixel_if.sink           in_pix,
  iis_result_if.source        out_res,
  input  wire                 cfg_we,
  input  iis_pkg::cfg_idx_t   cfg_idx,
  input  iis_pkg::cfg_data_t  cfg_wdata
);
  import iis_pkg::*;

  localparam int COL_W = $clog2(MAX_WIDTH);
  localparam int ROW_W = $clog2(MAX_HEIGHT);
  localparam int DW_W  = $clog2(MAX_WIDTH + 1);
  localparam int DH_W  = $clog2(MAX_HEIGHT + 1);
  localparam int CW_W  = (DW_W > CFG_W) ? DW_W : CFG_W;
  localparam int CH_W  = (DH_W > CFG_W) ? DH_W : CFG_W;
  localparam int RS_RAW  = $clog2(MAX_WIDTH * 255 + 1);
  localparam int RSQ_RAW = $clog2(MAX_WIDTH * 65025 + 1);
  localparam int RS_W  = (RS_RAW > SUM_W) ? SUM_W : RS_RAW;
  localparam int RSQ_W = (RSQ_RAW > SQ_STORE_W) ? SQ_STORE_W : RSQ_RAW;

  // Configuration and frame position
  cfg_data_t         width_r, height_r;
  logic [COL_W-1:0]  col_cnt_r;
  logic [ROW_W-1:0]  row_cnt_r;
  logic [RS_W-1:0]   rs_r;
  logic [RSQ_W-1:0]  rsq_r;

  // Stage one: pixel registered with its line store read
  logic              a_vld_r;
  logic [COL_W-1:0]  a_col_r;
  logic [RS_W-1:0]   a_rs_r;
  logic [RSQ_W-1:0]  a_rsq_r;
  logic              a_above_r;
  logic              a_row_end_r;
  logic              a_frame_end_r;
  sum_t              rd_sum_r;
  sq_store_t         rd_sq_r;
  logic              byp_r;
  sum_t              byp_sum_r;
  sq_store_t         byp_sq_r;

  // Stage two: result register
  logic              out_vld_r;
  sum_t              out_sum_r;
  sq_t               out_sq_r;
  logic              out_row_end_r;
  logic              out_frame_end_r;

  // Line stores
  sum_t              sum_mem [MAX_WIDTH];
  sq_store_t         sq_mem  [MAX_WIDTH];

  logic              cfg_hit;
  logic              in_fire, a_move, out_free;
  logic [CW_W-1:0]   w_ext, w_cl;
  logic [CH_W-1:0]   h_ext, h_cl;
  logic [DW_W-1:0]   w_eff;
  logic [DH_W-1:0]   h_eff;
  logic [COL_W-1:0]  col;
  logic              col_zero, last_col, last_row;
  logic [15:0]       pix_sq;
  logic [RS_W-1:0]   rs_nxt;
  logic [RSQ_W-1:0]  rsq_nxt;
  sum_t              above_sum, s_sum;
  sq_store_t         above_sq, s_sq;

  // Handshake: each stage advances when the one after it frees up
  assign out_free      = !out_vld_r || out_res.ready;
  assign a_move        = a_vld_r && out_free;
  assign in_pix.ready  = !a_vld_r || a_move;
  assign in_fire       = in_pix.valid && in_pix.ready;
  assign cfg_hit       = cfg_we && ((cfg_idx == REG_IMAGE_WIDTH) ||
                                    (cfg_idx == REG_IMAGE_HEIGHT));

  // Clamp the frame size into 1..MAX
  always_comb begin
    w_ext = CW_W'(width_r);
    h_ext = CH_W'(height_r);
    if (w_ext == '0) begin
      w_cl = CW_W'(1);
    end else if (w_ext > CW_W'(MAX_WIDTH)) begin
      w_cl = CW_W'(MAX_WIDTH);
    end else begin
      w_cl = w_ext;
    end
    if (h_ext == '0) begin
      h_cl = CH_W'(1);
    end else if (h_ext > CH_W'(MAX_HEIGHT)) begin
      h_cl = CH_W'(MAX_HEIGHT);
    end else begin
      h_cl = h_ext;
    end
    w_eff = w_cl[DW_W-1:0];
    h_eff = h_cl[DH_W-1:0];
  end

  // Column, row flags and running row sums of the incoming pixel
  always_comb begin
    if (DW_W'(col_cnt_r) >= w_eff) begin
      col = COL_W'(w_eff - DW_W'(1));
    end else begin
      col = col_cnt_r;
    end
    col_zero = (col == '0);
    last_col = (DW_W'(col) + DW_W'(1)) >= w_eff;
    last_row = (DH_W'(row_cnt_r) + DH_W'(1)) >= h_eff;
    pix_sq   = 16'(in_pix.pixel) * 16'(in_pix.pixel);
    rs_nxt   = (col_zero ? '0 : rs_r) + RS_W'(in_pix.pixel);
    rsq_nxt  = (col_zero ? '0 : rsq_r) + RSQ_W'(pix_sq);
  end

  // Add the previous row's value to the row sum
  always_comb begin
    if (!a_above_r) begin
      above_sum = '0;
      above_sq  = '0;
    end else if (byp_r) begin
      above_sum = byp_sum_r;
      above_sq  = byp_sq_r;
    end else begin
      above_sum = rd_sum_r;
      above_sq  = rd_sq_r;
    end
    s_sum = above_sum + SUM_W'(a_rs_r);
    s_sq  = above_sq + SQ_STORE_W'(a_rsq_r);
  end

  // Hold configuration, restarting the frame on a size write; advance frame position on each transfer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r   <= IMAGE_WIDTH_RST;
      height_r  <= IMAGE_HEIGHT_RST;
      col_cnt_r <= '0;
      row_cnt_r <= '0;
      rs_r      <= '0;
      rsq_r     <= '0;
    end else if (cfg_hit) begin
      if (cfg_idx == REG_IMAGE_WIDTH) begin
        width_r <= cfg_wdata;
      end else begin
        height_r <= cfg_wdata;
      end
      col_cnt_r <= '0;
      row_cnt_r <= '0;
      rs_r      <= '0;
      rsq_r     <= '0;
    end else if (in_fire) begin
      rs_r  <= rs_nxt;
      rsq_r <= rsq_nxt;
      if (last_col) begin
        col_cnt_r <= '0;
        row_cnt_r <= last_row ? '0 : row_cnt_r + ROW_W'(1);
      end else begin
        col_cnt_r <= col + COL_W'(1);
      end
    end
  end

  // Stage one control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_vld_r <= 1'b0;
    end else if (in_pix.ready) begin
      a_vld_r <= in_pix.valid;
    end
  end

  // Stage one payload and bypass of a same-column write
  always_ff @(posedge clk) begin
    if (in_fire) begin
      a_col_r       <= col;
      a_rs_r        <= rs_nxt;
      a_rsq_r       <= rsq_nxt;
      a_above_r     <= (row_cnt_r != '0);
      a_row_end_r   <= last_col;
      a_frame_end_r <= last_col && last_row;
      byp_r         <= a_move && (a_col_r == col);
      byp_sum_r     <= s_sum;
      byp_sq_r      <= s_sq;
    end
  end

  // Line stores: write the result, read the next pixel's column
  always_ff @(posedge clk) begin
    if (a_move) begin
      sum_mem[a_col_r] <= s_sum;
      sq_mem[a_col_r]  <= s_sq;
    end
    if (in_fire) begin
      rd_sum_r <= sum_mem[col];
      rd_sq_r  <= sq_mem[col];
    end
  end

  // Result register control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (out_free) begin
      out_vld_r <= a_vld_r;
    end
  end

  // Result register payload
  always_ff @(posedge clk) begin
    if (a_move) begin
      out_sum_r       <= s_sum;
      out_sq_r        <= s_sq[SQ_W-1:0];
      out_row_end_r   <= a_row_end_r;
      out_frame_end_r <= a_frame_end_r;
    end
  end

  assign out_res.valid           = out_vld_r;
  assign out_res.area_sum        = out_sum_r;
  assign out_res.area_square_sum = out_sq_r;
  assign out_res.row_end         = out_row_end_r;
  assign out_res.frame_end       = out_frame_end_r;

endmodule

`default_nettype wire

### rtl/iis_checker.sv
// ----------------------------------------------------------------------------
// Integral image stream checker
// Port-level assertions on the core, attached by bind.
// ----------------------------------------------------------------------------
`default_nettype none

module iis_checker (
  input wire                 clk,
  input wire                 rst_n,
  input wire                 in_valid,
  input wire                 in_ready,
  input wire                 out_valid,
  input wire                 out_ready,
  input iis_pkg::sum_t       area_sum,
  input wire                 row_end,
  input wire                 frame_end
);
  import iis_pkg::*;

  // Frame end is always also a row end
  a_frame_row: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && frame_end) |-> row_end)
    else $error("frame_end without row_end");

  // A new result appears only after an earlier input transfer
  a_rise_src: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_valid && in_ready, 2))
    else $error("result appeared without a preceding transfer");

  // Reset empties the result side
  a_rst_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

  // Stalled result holds its valid, sum and frame end
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> (out_valid && $stable(area_sum) &&
                                   $stable(frame_end)))
    else $error("stalled result changed");

endmodule

bind integral_image_stream_core iis_checker u_iis_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_pix.valid),
  .in_ready  (in_pix.ready),
  .out_valid (out_res.valid),
  .out_ready (out_res.ready),
  .area_sum  (out_res.area_sum),
  .row_end   (out_res.row_end),
  .frame_end (out_res.frame_end)
);

`default_nettype wire

### bench/integral_image_stream_core_test.sv
// ----------------------------------------------------------------------------
// Integral image stream core testbench
// Streams raster pixels through the core and checks every integral image and
// squared integral image result, plus the row and frame end flags, against a
// line-store predictor kept in step with each size register write. A short
// table of directed pixels and writes comes first. A wide frame and random
// frames follow, with random idling on both channels and one long result stall.
// ----------------------------------------------------------------------------
`default_nettype none

module integral_image_stream_core_test;
  timeunit 1ns;
  timeprecision 1ps;

  import iis_pkg::*;

  localparam int unsigned LINE_W           = 1024;
  localparam int unsigned LINE_H           = 1024;
  localparam int unsigned SETTLE_CYCLES    = 4;
  localparam int unsigned DRAIN_CYCLES     = 10;
  localparam int unsigned LONG_STALL       = 300;
  localparam int unsigned STALL_BURST      = 40;
  localparam int unsigned PHASE_PIXELS     = 80;
  localparam int unsigned REPORT_LIMIT     = 100;
  localparam int unsigned DIRECTED_LEN     = 26;

  // Indexes past the register list; writes there must be ignored
  localparam cfg_idx_t REG_SPARE_2 = 2'd2;
  localparam cfg_idx_t REG_SPARE_3 = 2'd3;

  typedef struct packed {
    sum_t area_sum;
    sq_t  area_square_sum;
    logic row_end;
    logic frame_end;
  } result_t;

  typedef enum logic {STEP_PIXEL, STEP_WRITE} step_kind_e;

  typedef struct packed {
    step_kind_e kind;
    cfg_idx_t   reg_idx;
    cfg_data_t  reg_value;
    pixel_t     pix;
    logic       checked;
    result_t    want;
  } step_t;

  // Directed rows: sizes at reset, sizes of zero, sizes past the maximum,
  // ignored indexes mid-frame, a restart mid-frame and a frame wrap.
  localparam step_t DIRECTED_STEPS [DIRECTED_LEN] = '{
    '{STEP_PIXEL, REG_IMAGE_WIDTH,  11'd0,    8'd255, 1'b1, '{28'd255, 36'd65025, 1'b0, 1'b0}},
    '{STEP_PIXEL, REG_IMAGE_WIDTH,  11'd0,    8'd0,   1'b1, '{28'd255, 36'd65025, 1'b0, 1'b0}},
    '{STEP_WRITE, REG_IMAGE_WIDTH,  11'd0,    8'd0,   1'b0, '0},
    '{STEP_WRITE, REG_IMAGE_HEIGHT, 11'd0,    8'd0,   1'b0, '0},
    '{STEP_PIXEL, REG_IMAGE_WIDTH,  11'd0,    8'd255, 1'b1, '{28'd255, 36'd65025, 1'b1, 1'b1}},
    '{STEP_PIXEL, REG_IMAGE_WIDTH,  11'd0,    8'd170, 1'b1, '{28'd170, 36'd28900, 1'b1, 1'b1}},
    '{STEP_WRITE, REG_IMAGE_WIDTH,  11'd2,    8'd0,   1'b0, '0},
    '{STEP_WRITE, REG_IMAGE_HEIGHT, 11'd2047, 8'd0,   1'b0, '0},
    '{STEP_PIXEL, REG_IMAGE_WIDTH,  11'd0,    8'd1,   1'b1, '{28'd1, 36'd1, 1'b0, 1'b0}},
    '{STEP_PIXEL, REG_IMAGE_WIDTH,  11'd0,    8'd2,   1'b1, '{28'd3, 36'd5, 1'b1, 1'b0}},
    '{STEP_PIXEL, REG_IMAGE_WIDTH,  11'd0,    8'd4,   1'b1, '{28'd5, 36'd17, 1'b0, 1'b0}},
    '{STEP_PIXEL, REG_IMAGE_WIDTH,  11'd0,    8'd8,   1'b1, '{28'd15, 36'd85, 1'b1, 1'b0}},
    '{STEP_WRITE, REG_SPARE_2,      11'd2047, 8'd0,   1'b0, '0},
    '{STEP_PIXEL, REG_IMAGE_WIDTH,  11'd0,    8'd0,   1'b1, '{28'd5, 36'd17, 1'b0, 1'b0}},
    '{STEP_WRITE, REG_SPARE_3,      11'd0,    8'd0,   1'b0, '0},
    '{STEP_PIXEL, REG_IMAGE_WIDTH,  11'd0,    8'd255, 1'b1, '{28'd270, 36'd65110, 1'b1, 1'b0}},
    '{STEP_WRITE, REG_IMAGE_HEIGHT, 11'd2,    8'd0,   1'b0, '0},
    '{STEP_PIXEL, REG_IMAGE_WIDTH,  11'd0,    8'd16,  1'b1, '{28'd16, 36'd256, 1'b0, 1'b0}},
    '{STEP_PIXEL, REG_IMAGE_WIDTH,  11'd0,    8'd32,  1'b1, '{28'd48, 36'd1280, 1'b1, 1'b0}},
    '{STEP_PIXEL, REG_IMAGE_WIDTH,  11'd0,    8'd64,  1'b1, '{28'd80, 36'd4352, 1'b0, 1'b0}},
    '{STEP_PIXEL, REG_IMAGE_WIDTH,  11'd0,    8'd128, 1'b1, '{28'd240, 36'd21760, 1'b1, 1'b1}},
    '{STEP_PIXEL, REG_IMAGE_WIDTH,  11'd0,    8'd85,  1'b1, '{28'd85, 36'd7225, 1'b0, 1'b0}},
    '{STEP_WRITE, REG_IMAGE_WIDTH,  11'd3,    8'd0,   1'b0, '0},
    '{STEP_PIXEL, REG_IMAGE_WIDTH,  11'd0,    8'd1,   1'b0, '0},
    '{STEP_PIXEL, REG_IMAGE_WIDTH,  11'd0,    8'd2,   1'b0, '0},
    '{STEP_PIXEL, REG_IMAGE_WIDTH,  11'd0,    8'd3,   1'b0, '0}
  };

  logic      clk = 1'b0;
  logic      rst_n;
  logic      cfg_we;
  cfg_idx_t  cfg_idx;
  cfg_data_t cfg_wdata;

  iis_pixel_if  pix_ch ();
  iis_result_if res_ch ();

  integral_image_stream_core uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_pix    (pix_ch),
    .out_res   (res_ch),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata)
  );

  // Predictor state: sizes, position, row sums and the two line stores
  cfg_data_t   width_reg;
  cfg_data_t   height_reg;
  int unsigned col_pos;
  int unsigned row_pos;
  logic [17:0] row_sum;
  logic [25:0] row_sq_sum;
  sum_t        line_sums [LINE_W];
  sq_store_t   line_sq_sums [LINE_W];

  result_t     awaited_sums [$];
  int unsigned error_count = 0;
  int unsigned send_idle_pct = 0;
  int unsigned sink_idle_pct = 0;
  int unsigned stall_requests = 0;
  int unsigned stall_served = 0;

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  function automatic int unsigned clamp_size(cfg_data_t value, int unsigned limit);
    if (value == 0) return 1;
    if (value > limit) return limit;
    return value;
  endfunction

  function automatic void restart_frame();
    col_pos    = 0;
    row_pos    = 0;
    row_sum    = '0;
    row_sq_sum = '0;
  endfunction

  // Fold one pixel into the row sums and the line stores; return its result
  function automatic result_t advance_integral(pixel_t p);
    int unsigned w;
    int unsigned h;
    sum_t        above;
    sq_store_t   above_sq;
    result_t     r;
    w = clamp_size(width_reg, LINE_W);
    h = clamp_size(height_reg, LINE_H);
    if (col_pos >= w) col_pos = w - 1;
    if (col_pos == 0) begin
      row_sum    = '0;
      row_sq_sum = '0;
    end
    row_sum    = row_sum + 18'(p);
    row_sq_sum = row_sq_sum + 26'(p) * 26'(p);
    above    = '0;
    above_sq = '0;
    if (row_pos != 0) begin
      above    = line_sums[col_pos];
      above_sq = line_sq_sums[col_pos];
    end
    line_sums[col_pos]    = above + SUM_W'(row_sum);
    line_sq_sums[col_pos] = above_sq + SQ_STORE_W'(row_sq_sum);
    r.area_sum        = line_sums[col_pos];
    r.area_square_sum = line_sq_sums[col_pos][SQ_W-1:0];
    r.row_end         = (col_pos + 1 >= w);
    r.frame_end       = r.row_end && (row_pos + 1 >= h);
    if (r.row_end) begin
      col_pos = 0;
      row_pos = r.frame_end ? 0 : row_pos + 1;
    end else begin
      col_pos++;
    end
    return r;
  endfunction

  function automatic pixel_t random_pixel();
    if ($urandom_range(99) < 25) return $urandom_range(1) ? 8'd255 : 8'd0;
    return pixel_t'($urandom_range(255));
  endfunction

  function automatic cfg_data_t pick_size();
    int unsigned roll;
    roll = $urandom_range(99);
    if (roll < 6) return '0;
    if (roll < 10) return cfg_data_t'($urandom_range(2047, 1025));
    if (roll < 20) return cfg_data_t'($urandom_range(40, 9));
    return cfg_data_t'($urandom_range(8, 1));
  endfunction

  task automatic wait_for_results();
    while (awaited_sums.size() != 0) @(negedge clk);
  endtask

  // Write a register once the core has gone quiet
  task automatic write_register(cfg_idx_t idx, cfg_data_t value);
    wait_for_results();
    repeat (SETTLE_CYCLES) @(negedge clk);
    cfg_we    = 1'b1;
    cfg_idx   = idx;
    cfg_wdata = value;
    @(negedge clk);
    cfg_we = 1'b0;
    case (idx)
      REG_IMAGE_WIDTH: begin
        width_reg = value;
        restart_frame();
      end
      REG_IMAGE_HEIGHT: begin
        height_reg = value;
        restart_frame();
      end
      default: ;
    endcase
  endtask

  // Offer one pixel, hold it until the transfer, then queue its result
  task automatic send_pixel(pixel_t p, logic checked, result_t want);
    result_t r;
    while ($urandom_range(99) < send_idle_pct) @(negedge clk);
    pix_ch.valid = 1'b1;
    pix_ch.pixel = p;
    do @(posedge clk); while (!pix_ch.ready);
    r = advance_integral(p);
    awaited_sums.push_back(checked ? want : r);
    @(negedge clk);
    pix_ch.valid = 1'b0;
  endtask

  // Result side: random back-pressure, plus a long hold-off on request
  initial begin : result_sink
    int unsigned stall_left;
    stall_left   = 0;
    res_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (stall_served != stall_requests) begin
        stall_served++;
        stall_left = LONG_STALL;
      end
      if (stall_left != 0) begin
        res_ch.ready = 1'b0;
        stall_left--;
      end else begin
        res_ch.ready = ($urandom_range(99) >= sink_idle_pct);
      end
    end
  end

  // Compare each result transfer with the oldest queued expectation
  always @(posedge clk) begin : result_check
    result_t got;
    result_t want;
    if (rst_n && res_ch.valid && res_ch.ready) begin
      got = '{res_ch.area_sum, res_ch.area_square_sum, res_ch.row_end, res_ch.frame_end};
      if (awaited_sums.size() == 0) begin
        error_count++;
        if (error_count <= REPORT_LIMIT)
          $display("%0t: unexpected result sum=%0d sq=%0d row_end=%0b frame_end=%0b",
                   $time, got.area_sum, got.area_square_sum, got.row_end, got.frame_end);
      end else begin
        want = awaited_sums.pop_front();
        if (got !== want) begin
          error_count++;
          if (error_count <= REPORT_LIMIT)
            $display({"%0t: expected sum=%0d sq=%0d row_end=%0b frame_end=%0b, ",
                      "got sum=%0d sq=%0d row_end=%0b frame_end=%0b"},
                     $time, want.area_sum, want.area_square_sum, want.row_end,
                     want.frame_end, got.area_sum, got.area_square_sum, got.row_end,
                     got.frame_end);
        end
      end
    end
  end

  initial begin : watchdog
    #5_000_000;
    $display("tb: failure");
    $finish;
  end

  initial begin : stimulus
    int unsigned sent;
    int unsigned burst;
    int unsigned w_eff;
    int unsigned h_eff;
    rst_n        = 1'b0;
    cfg_we       = 1'b0;
    cfg_idx      = REG_IMAGE_WIDTH;
    cfg_wdata    = '0;
    pix_ch.valid = 1'b0;
    pix_ch.pixel = '0;
    width_reg    = IMAGE_WIDTH_RST;
    height_reg   = IMAGE_HEIGHT_RST;
    restart_frame();
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Walk the directed table
    for (int i = 0; i < DIRECTED_LEN; i++) begin
      if (DIRECTED_STEPS[i].kind == STEP_WRITE)
        write_register(DIRECTED_STEPS[i].reg_idx, DIRECTED_STEPS[i].reg_value);
      else
        send_pixel(DIRECTED_STEPS[i].pix, DIRECTED_STEPS[i].checked, DIRECTED_STEPS[i].want);
    end

    // Full-width row and the start of the next, so the line store is read back
    write_register(REG_IMAGE_WIDTH, 11'd2047);
    write_register(REG_IMAGE_HEIGHT, 11'd2);
    repeat (LINE_W + 8) send_pixel(random_pixel(), 1'b0, '0);

    // Random frames under three idling patterns
    for (int phase = 0; phase < 3; phase++) begin
      sent = 0;
      case (phase)
        0: begin
          send_idle_pct = 34;
          sink_idle_pct = 82;
        end
        1: begin
          send_idle_pct = 82;
          sink_idle_pct = 34;
        end
        default: begin
          send_idle_pct = 0;
          sink_idle_pct = 0;
          // Hold off results while pixels keep coming, so the core backs up
          write_register(REG_IMAGE_WIDTH, 11'd7);
          write_register(REG_IMAGE_HEIGHT, 11'd5);
          stall_requests++;
          repeat (STALL_BURST) send_pixel(random_pixel(), 1'b0, '0);
          sent = STALL_BURST;
        end
      endcase
      while (sent < PHASE_PIXELS) begin
        if ($urandom_range(99) < 60) write_register(REG_IMAGE_WIDTH, pick_size());
        if ($urandom_range(99) < 60) write_register(REG_IMAGE_HEIGHT, pick_size());
        if ($urandom_range(99) < 15)
          write_register($urandom_range(1) ? REG_SPARE_2 : REG_SPARE_3,
                         cfg_data_t'($urandom));
        w_eff = clamp_size(width_reg, LINE_W);
        h_eff = clamp_size(height_reg, LINE_H);
        if (w_eff * h_eff <= 50)
          burst = w_eff * h_eff * $urandom_range(2, 1) + $urandom_range(w_eff - 1, 0);
        else
          burst = $urandom_range(20, 4);
        repeat (burst) send_pixel(random_pixel(), 1'b0, '0);
        sent += burst;
      end
    end

    // Let the last results drain, then report
    wait_for_results();
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (error_count == 0)
      $display("tb: success");
    else
      $display("tb: failure");
    $finish;
  end

endmodule

`default_nettype wire
